// File: rtl/core/hcox_pkg.sv
`default_nettype none

package hcox_pkg;

  localparam int MAX_CITIES_DEF = 1024;
  localparam int ID_W           = 10;
  localparam int CFG_W          = 11;
  localparam int EPOCH_W        = 8;

  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;
  localparam int REG_IDX_W      = APB_ADDR_W - 2;

  localparam logic [CFG_W-1:0]     NUM_CITIES_RST = CFG_W'(1024);
  localparam logic [REG_IDX_W-1:0] REG_NUM_CITIES = REG_IDX_W'(0);

endpackage

`default_nettype wire

// File: rtl/core/hcox_apb_regs.sv
`default_nettype none

module hcox_apb_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [hcox_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [hcox_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [hcox_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                   pready,
  output logic      [hcox_pkg::CFG_W-1:0]        num_cities_o
);

  logic [hcox_pkg::CFG_W-1:0]     num_cities_q;
  logic [hcox_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           wr_en;

  assign reg_idx = paddr[hcox_pkg::APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_cities_q <= hcox_pkg::NUM_CITIES_RST;
    end else if (wr_en && (reg_idx == hcox_pkg::REG_NUM_CITIES)) begin
      num_cities_q <= pwdata[hcox_pkg::CFG_W-1:0];
    end
  end

  always_comb begin
    if (reg_idx == hcox_pkg::REG_NUM_CITIES) begin
      prdata = hcox_pkg::APB_DATA_W'(num_cities_q);
    end else begin
      prdata = '0;
    end
  end

  assign num_cities_o = num_cities_q;

endmodule

`default_nettype wire

// File: rtl/core/hcox_tag_ram.sv
`default_nettype none

module hcox_tag_ram #(
  parameter int DEPTH = hcox_pkg::MAX_CITIES_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic                             clk_i,
  input  wire logic                             we_i,
  input  wire logic [ADDR_W-1:0]                waddr_i,
  input  wire logic [hcox_pkg::EPOCH_W-1:0]     wdata_i,
  input  wire logic                             re_i,
  input  wire logic [ADDR_W-1:0]                raddr_i,
  output logic      [hcox_pkg::EPOCH_W-1:0]     rdata_o
);

  logic [hcox_pkg::EPOCH_W-1:0] mem [DEPTH];
  logic [hcox_pkg::EPOCH_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/core/half_cut_order_crossover.sv
// A child city goes from the input stage register to the output register; output stalls hold it.
// Throughput: one city id per cycle via the tag RAM read-modify-write, unless stalled.
// Visited marks are epoch tags, so a new parent pair starts without a clear.
// Reset: counters zero, num_cities 1024, epoch 1, then a tag RAM clear over all MAX_CITIES
// entries with input held off; after every 255th parent pair the same clear runs and the
// input is held off until it ends.
`default_nettype none

module half_cut_order_crossover #(
  parameter int MAX_CITIES = hcox_pkg::MAX_CITIES_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [hcox_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [hcox_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [hcox_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [hcox_pkg::ID_W-1:0]       city_id_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic      [hcox_pkg::ID_W-1:0]       child_city_o,
  output logic                                 child_last_o
);

  localparam int ADDR_W = $clog2(MAX_CITIES);
  localparam int CNT_W  = $clog2(MAX_CITIES) + 1;
  localparam int POS_W  = CNT_W + 1;
  localparam int WIDE_W = (CNT_W > hcox_pkg::CFG_W) ? CNT_W : hcox_pkg::CFG_W;
  localparam int IDX_W  = (hcox_pkg::ID_W > ADDR_W + 1) ? hcox_pkg::ID_W : ADDR_W + 1;

  logic [hcox_pkg::CFG_W-1:0]   num_cities;
  logic [WIDE_W-1:0]            ncfg_w;
  logic [CNT_W-1:0]             eff_n;

  logic                         s1_valid_q;
  logic [ADDR_W-1:0]            s1_addr_q;
  logic [hcox_pkg::ID_W-1:0]    s1_id_q;
  logic                         s1_inr_q;

  logic [POS_W-1:0]             items_q;
  logic [CNT_W-1:0]             emitted_q;
  logic [hcox_pkg::EPOCH_W-1:0] epoch_q;
  logic                         fwd_v_q;
  logic [ADDR_W-1:0]            fwd_addr_q;
  logic                         clr_q;
  logic [ADDR_W-1:0]            clr_addr_q;

  logic                         out_valid_q;
  logic [hcox_pkg::ID_W-1:0]    child_city_q;
  logic                         child_last_q;

  logic [IDX_W-1:0]             id_wide;
  logic                         id_inr;
  logic [ADDR_W-1:0]            id_addr;
  logic                         accept;

  logic [hcox_pkg::EPOCH_W-1:0] rdata;
  logic                         visited;
  logic                         pos_lt_n;
  logic                         pos_lt_half;
  logic                         cand;
  logic                         emit;
  logic [POS_W:0]               pos_inc;
  logic                         end_pair;
  logic                         last;
  logic                         proc;
  logic                         wrap;

  logic                         ram_we;
  logic [ADDR_W-1:0]            ram_waddr;
  logic [hcox_pkg::EPOCH_W-1:0] ram_wdata;

  hcox_apb_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .num_cities_o (num_cities)
  );

  assign ncfg_w = WIDE_W'(num_cities);

  always_comb begin
    if (ncfg_w < WIDE_W'(2)) begin
      eff_n = CNT_W'(2);
    end else if (ncfg_w > WIDE_W'(MAX_CITIES)) begin
      eff_n = CNT_W'(MAX_CITIES);
    end else begin
      eff_n = ncfg_w[CNT_W-1:0];
    end
  end

  assign id_wide = IDX_W'(city_id_i);
  assign id_inr  = id_wide < IDX_W'(MAX_CITIES);
  assign id_addr = id_wide[ADDR_W-1:0];
  assign accept  = in_valid_i && in_ready_o;

  hcox_tag_ram #(
    .DEPTH (MAX_CITIES)
  ) u_tags (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (id_addr),
    .rdata_o (rdata)
  );

  // forward covers the write issued in the same cycle as this item's read
  assign visited     = s1_inr_q && ((rdata == epoch_q) ||
                                    (fwd_v_q && (fwd_addr_q == s1_addr_q)));
  assign pos_lt_n    = items_q < POS_W'(eff_n);
  assign pos_lt_half = items_q < POS_W'(eff_n >> 1);
  assign cand        = pos_lt_n ? pos_lt_half : !visited;
  assign emit        = s1_valid_q && cand && (emitted_q < eff_n);
  assign pos_inc     = {1'b0, items_q} + (POS_W + 1)'(1);
  assign end_pair    = pos_inc >= (POS_W + 1)'({eff_n, 1'b0});
  assign last        = ((emitted_q + CNT_W'(1)) == eff_n) || end_pair;
  assign proc        = s1_valid_q && (!emit || !out_valid_q || out_ready_i);
  assign wrap        = end_pair && (epoch_q == '1);
  assign in_ready_o  = !clr_q && (!s1_valid_q || proc) && !(proc && wrap);

  assign ram_we    = clr_q || (proc && emit && s1_inr_q);
  assign ram_waddr = clr_q ? clr_addr_q : s1_addr_q;
  assign ram_wdata = clr_q ? '0 : epoch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      items_q     <= '0;
      emitted_q   <= '0;
      epoch_q     <= hcox_pkg::EPOCH_W'(1);
      fwd_v_q     <= 1'b0;
      fwd_addr_q  <= '0;
      clr_q       <= 1'b1;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (proc) begin
        s1_valid_q <= 1'b0;
      end

      if (proc) begin
        if (end_pair) begin
          items_q   <= '0;
          emitted_q <= '0;
          fwd_v_q   <= 1'b0;
          if (wrap) begin
            epoch_q    <= hcox_pkg::EPOCH_W'(1);
            clr_q      <= 1'b1;
            clr_addr_q <= '0;
          end else begin
            epoch_q <= epoch_q + hcox_pkg::EPOCH_W'(1);
          end
        end else begin
          items_q <= pos_inc[POS_W-1:0];
          if (emit) begin
            emitted_q <= emitted_q + CNT_W'(1);
          end
          if (emit && s1_inr_q) begin
            fwd_v_q    <= 1'b1;
            fwd_addr_q <= s1_addr_q;
          end
        end
      end

      if (clr_q) begin
        clr_addr_q <= clr_addr_q + ADDR_W'(1);
        if (clr_addr_q == ADDR_W'(MAX_CITIES - 1)) begin
          clr_q <= 1'b0;
        end
      end

      if (proc && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_addr_q <= id_addr;
      s1_id_q   <= city_id_i;
      s1_inr_q  <= id_inr;
    end
    if (proc && emit) begin
      child_city_q <= s1_id_q;
      child_last_q <= last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign child_city_o = child_city_q;
  assign child_last_o = child_last_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) clr_q |-> !in_ready_o)
    else $error("input taken during tag clear");

  assert property (@(posedge clk_i) disable iff (!rst_ni) clr_q |-> !s1_valid_q)
    else $error("pipeline busy during tag clear");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && end_pair) |=> (items_q == '0 && emitted_q == '0 && !fwd_v_q))
    else $error("pair state not cleared");

  assert property (@(posedge clk_i) disable iff (!rst_ni) epoch_q != '0)
    else $error("epoch collides with cleared tag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !(proc && emit))
    else $error("result overwritten while stalled");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned LIMIT = 400000;
  localparam int unsigned RAND_ITEMS = 480;
  localparam int unsigned CALM_AFTER = 380;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned HOLD_ITEMS = 40;
  localparam logic [hcox_pkg::REG_IDX_W-1:0] REG_SPARE = hcox_pkg::REG_IDX_W'(1);

  typedef struct packed {
    logic [hcox_pkg::ID_W-1:0] city;
    logic                      last;
  } child_t;

  typedef enum logic [1:0] {ROW_CITY, ROW_WRITE, ROW_WRITE_SPARE} row_kind_e;

  typedef struct packed {
    row_kind_e                  kind;
    logic [hcox_pkg::CFG_W-1:0] val;
    logic                       typed;
    logic                       emits;
    logic [hcox_pkg::ID_W-1:0]  city;
    logic                       last;
  } row_t;

  localparam row_t PLAN [30] = '{
    '{ROW_CITY,  11'h3FF, 1'b1, 1'b1, 10'h3FF, 1'b0},
    '{ROW_CITY,  11'h000, 1'b1, 1'b1, 10'h000, 1'b0},
    '{ROW_CITY,  11'h200, 1'b1, 1'b1, 10'h200, 1'b0},
    '{ROW_WRITE, 11'd1024, 1'b0, 1'b0, 10'h000, 1'b0},
    '{ROW_CITY,  11'h155, 1'b1, 1'b1, 10'h155, 1'b0},
    '{ROW_CITY,  11'h2AA, 1'b1, 1'b1, 10'h2AA, 1'b0},
    // shrink mid-pair: position already past the end, next city closes the pair
    '{ROW_WRITE, 11'd2,   1'b0, 1'b0, 10'h000, 1'b0},
    '{ROW_CITY,  11'h3FF, 1'b1, 1'b0, 10'h000, 1'b0},
    '{ROW_CITY,  11'h3FF, 1'b1, 1'b1, 10'h3FF, 1'b0},
    '{ROW_CITY,  11'h000, 1'b1, 1'b0, 10'h000, 1'b0},
    '{ROW_CITY,  11'h000, 1'b1, 1'b1, 10'h000, 1'b1},
    '{ROW_CITY,  11'h3FF, 1'b1, 1'b0, 10'h000, 1'b0},
    // short child, no last flag
    '{ROW_WRITE, 11'd1,   1'b0, 1'b0, 10'h000, 1'b0},
    '{ROW_CITY,  11'd5,   1'b1, 1'b1, 10'd5,   1'b0},
    '{ROW_CITY,  11'd6,   1'b1, 1'b0, 10'h000, 1'b0},
    '{ROW_CITY,  11'd5,   1'b1, 1'b0, 10'h000, 1'b0},
    '{ROW_CITY,  11'd5,   1'b1, 1'b0, 10'h000, 1'b0},
    // full child before the pair ends, stray city dropped
    '{ROW_WRITE, 11'd0,   1'b0, 1'b0, 10'h000, 1'b0},
    '{ROW_CITY,  11'd7,   1'b1, 1'b1, 10'd7,   1'b0},
    '{ROW_CITY,  11'd8,   1'b1, 1'b0, 10'h000, 1'b0},
    '{ROW_CITY,  11'd9,   1'b1, 1'b1, 10'd9,   1'b1},
    '{ROW_CITY,  11'd8,   1'b1, 1'b0, 10'h000, 1'b0},
    '{ROW_WRITE, 11'd3,   1'b0, 1'b0, 10'h000, 1'b0},
    '{ROW_WRITE_SPARE, 11'd2, 1'b0, 1'b0, 10'h000, 1'b0},
    '{ROW_CITY,  11'd10,  1'b0, 1'b0, 10'h000, 1'b0},
    '{ROW_CITY,  11'd11,  1'b0, 1'b0, 10'h000, 1'b0},
    '{ROW_CITY,  11'd12,  1'b0, 1'b0, 10'h000, 1'b0},
    '{ROW_CITY,  11'd12,  1'b0, 1'b0, 10'h000, 1'b0},
    '{ROW_CITY,  11'd11,  1'b0, 1'b0, 10'h000, 1'b0},
    '{ROW_CITY,  11'd10,  1'b0, 1'b0, 10'h000, 1'b0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [hcox_pkg::APB_ADDR_W-1:0] paddr;
  logic [hcox_pkg::APB_DATA_W-1:0] pwdata;
  logic [hcox_pkg::APB_DATA_W-1:0] prdata;
  logic pready;
  logic in_valid_i;
  logic in_ready_o;
  logic [hcox_pkg::ID_W-1:0] city_id_i;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [hcox_pkg::ID_W-1:0] child_city_o;
  logic child_last_o;

  half_cut_order_crossover uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .city_id_i   (city_id_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .child_city_o(child_city_o),
    .child_last_o(child_last_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // crossover state mirror
  bit                         city_seen [hcox_pkg::MAX_CITIES_DEF];
  int unsigned                pair_pos;
  int unsigned                child_len;
  logic [hcox_pkg::CFG_W-1:0] cfg_cities;

  child_t      child_q [$];
  int unsigned fails;
  int unsigned cycles;
  int unsigned cities_sent;
  bit          quiet;
  bit          tx_choppy;
  bit          long_hold_req;

  function automatic int unsigned span_of(input logic [hcox_pkg::CFG_W-1:0] raw);
    if (raw < 2) return 2;
    if (raw > hcox_pkg::MAX_CITIES_DEF) return hcox_pkg::MAX_CITIES_DEF;
    return 32'(raw);
  endfunction

  function automatic bit crossover_step(input logic [hcox_pkg::ID_W-1:0] id,
                                        output child_t c);
    int unsigned n;
    bit tail;
    bit take;
    n = span_of(cfg_cities);
    tail = (pair_pos + 1 >= 2 * n);
    if (pair_pos < n) take = (pair_pos < n / 2);
    else take = !city_seen[id];
    if (child_len >= n) take = 1'b0;
    c.city = id;
    c.last = 1'b0;
    if (take) begin
      city_seen[id] = 1'b1;
      child_len++;
      c.last = (child_len == n) || tail;
    end
    if (tail) begin
      foreach (city_seen[i]) city_seen[i] = 1'b0;
      pair_pos = 0;
      child_len = 0;
    end else begin
      pair_pos++;
    end
    return take;
  endfunction

  task automatic send_city(input logic [hcox_pkg::ID_W-1:0] id, input bit typed,
                           input bit t_emit, input child_t t_child);
    child_t c;
    bit hit;
    if (tx_choppy && !quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    city_id_i <= id;
    do @(posedge clk_i); while (!in_ready_o);
    cities_sent++;
    hit = crossover_step(id, c);
    if (typed) begin
      if (t_emit) child_q = {child_q, t_child};
    end else if (hit) begin
      child_q = {child_q, c};
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (child_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [hcox_pkg::REG_IDX_W-1:0] idx,
                           input logic [hcox_pkg::APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == hcox_pkg::REG_NUM_CITIES) cfg_cities = data[hcox_pkg::CFG_W-1:0];
  endtask

  task automatic feed_pair(input int unsigned n, input bit broken);
    logic [hcox_pkg::ID_W-1:0] first [$];
    logic [hcox_pkg::ID_W-1:0] second [$];
    bit used [hcox_pkg::MAX_CITIES_DEF];
    logic [hcox_pkg::ID_W-1:0] v;
    logic [hcox_pkg::ID_W-1:0] t;
    int unsigned j;
    while (first.size() < n) begin
      v = hcox_pkg::ID_W'($urandom);
      if (broken && first.size() > 0 && $urandom_range(0, 2) == 0) begin
        first = {first, first[$urandom_range(0, first.size() - 1)]};
      end else if (!used[v]) begin
        used[v] = 1'b1;
        first = {first, v};
      end
    end
    second = first;
    for (int i = second.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      t = second[i];
      second[i] = second[j];
      second[j] = t;
    end
    if (broken) begin
      foreach (second[i]) if ($urandom_range(0, 2) == 0) second[i] = hcox_pkg::ID_W'($urandom);
    end
    foreach (first[i]) send_city(first[i], 1'b0, 1'b0, '0);
    foreach (second[i]) send_city(second[i], 1'b0, 1'b0, '0);
  endtask

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("%0t timeout", $time);
      $display("half_cut_order_crossover: mismatch");
      $finish;
    end
  end

  int unsigned rx_stall;
  bit          rx_choppy;

  always @(posedge clk_i) begin : rx_side
    child_t want;
    if (out_valid_o && out_ready_i) begin
      if (child_q.size() == 0) begin
        fails++;
        if (fails <= 100)
          $display("%0t unexpected transfer: city %0d last %0d", $time, child_city_o,
                   child_last_o);
      end else begin
        want = child_q.pop_front();
        if (child_city_o !== want.city || child_last_o !== want.last) begin
          fails++;
          if (fails <= 100)
            $display("%0t expected city %0d last %0d, got city %0d last %0d", $time,
                     want.city, want.last, child_city_o, child_last_o);
        end
      end
    end
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      rx_stall = LONG_HOLD;
    end
    if (!quiet && $urandom_range(0, 63) == 0) rx_choppy = !rx_choppy;
    if (rx_stall > 0) begin
      rx_stall--;
      out_ready_i <= 1'b0;
    end else if (rx_choppy && !quiet && $urandom_range(0, 3) == 0) begin
      rx_stall = $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    int unsigned base;
    int unsigned n;
    logic [hcox_pkg::CFG_W-1:0] raw;
    int unsigned r;
    rst_ni <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_valid_i <= 1'b0;
    city_id_i <= '0;
    cfg_cities = hcox_pkg::NUM_CITIES_RST;
    pair_pos = 0;
    child_len = 0;
    tx_choppy = 1'b1;
    rx_choppy = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (PLAN[i]) begin
      if (PLAN[i].kind == ROW_CITY) begin
        send_city(PLAN[i].val[hcox_pkg::ID_W-1:0], PLAN[i].typed, PLAN[i].emits,
                  child_t'{PLAN[i].city, PLAN[i].last});
      end else begin
        wait_idle();
        apb_write(PLAN[i].kind == ROW_WRITE ? hcox_pkg::REG_NUM_CITIES : REG_SPARE,
                  hcox_pkg::APB_DATA_W'(PLAN[i].val));
      end
    end

    // largest tour, with the receiver holding off while the input backs up
    wait_idle();
    apb_write(hcox_pkg::REG_NUM_CITIES, hcox_pkg::APB_DATA_W'(11'd2047));
    long_hold_req = 1'b1;
    repeat (HOLD_ITEMS) send_city(hcox_pkg::ID_W'($urandom), 1'b0, 1'b0, '0);

    base = cities_sent;
    while (cities_sent - base < RAND_ITEMS) begin
      wait_idle();
      r = $urandom_range(0, 19);
      if (r == 0) raw = hcox_pkg::CFG_W'($urandom_range(0, 1));
      else if (r < 14) raw = hcox_pkg::CFG_W'($urandom_range(2, 6));
      else raw = hcox_pkg::CFG_W'($urandom_range(7, 40));
      apb_write(hcox_pkg::REG_NUM_CITIES, {21'($urandom), raw});
      if ($urandom_range(0, 9) == 0) apb_write(REG_SPARE, $urandom);
      n = span_of(raw);
      tx_choppy = ($urandom_range(0, 2) != 0);
      repeat ($urandom_range(1, 4)) feed_pair(n, $urandom_range(0, 4) == 0);
      if ($urandom_range(0, 5) == 0) begin
        repeat ($urandom_range(1, 2 * n - 1))
          send_city(hcox_pkg::ID_W'($urandom), 1'b0, 1'b0, '0);
      end
      quiet = (cities_sent - base >= CALM_AFTER);
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    if (fails == 0) begin
      $display("half_cut_order_crossover: match");
    end else begin
      $display("half_cut_order_crossover: mismatch");
    end
    $finish;
  end

endmodule

// File: half_cut_order_crossover.f
rtl/core/hcox_pkg.sv
rtl/core/hcox_apb_regs.sv
rtl/core/hcox_tag_ram.sv
rtl/core/half_cut_order_crossover.sv
tb/tb_top.sv
